/* sv/gct_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and defaults for the grid cell triangulator.
// No dependencies; gct_ctrl, gct_datapath and the top level import it.
package gct_pkg;

    // Default geometry and index width
    localparam int GRID_W_DEF     = 32;
    localparam int GRID_H_DEF     = 32;
    localparam int INDEX_BITS_DEF = 16;

    // Fixed field widths of the channel words
    localparam int KIND_W   = 2;
    localparam int COORD_W  = 5;
    localparam int VIDX_W   = 16;
    localparam int CORNER_W = 16;

    // Input word kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROW    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [VIDX_W-1:0]  vertex_index;
    } gct_in_t;

    typedef struct packed {
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic                has_triangle;
        logic                last;
    } gct_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture the accepted input word
        logic clr_wr;   // write one empty cell of the clearing sweep
        logic ins_rd;   // read the target cell of an insert
        logic ins_wr;   // store the index if the cell was empty
        logic scan;     // run the row scan pipeline
        logic flush;    // close the row with the last result
    } gct_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;   // sweep is at the final cell
        logic scan_done;  // every column read and evaluated
        logic flush_done; // final result moved to the output register
    } gct_sts_t;

endpackage

/* sv/gct_ram.sv */
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module gct_ram #(
    parameter int WIDTH  = 17,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports; hold the data while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* sv/gct_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the grid cell triangulator.
// Depends on gct_pkg for the command and status structs and the kind codes.
module gct_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [gct_pkg::KIND_W-1:0] kind,
    input  gct_pkg::gct_sts_t         sts,
    output gct_pkg::gct_cmd_t         cmd
);
    import gct_pkg::*;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_INS_RD = 3'd2;
    localparam logic [2:0] ST_INS_WR = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_FLUSH  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register; reset starts with the clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    unique case (kind)
                        KIND_INSERT: state_next = ST_INS_RD;
                        KIND_ROW:    state_next = ST_SCAN;
                        KIND_CLEAR:  state_next = ST_CLEAR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INS_RD: begin
                cmd.ins_rd = 1'b1;
                state_next = ST_INS_WR;
            end
            ST_INS_WR: begin
                cmd.ins_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                cmd.flush = 1'b1;
                if (sts.flush_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/gct_datapath.sv */
`timescale 1ns / 1ps
// Datapath: grid store, clearing sweep, insert check, row scan pipeline,
// pending triangle and output register. Depends on gct_pkg and gct_ram.
module gct_datapath #(
    parameter int GRID_W     = gct_pkg::GRID_W_DEF,
    parameter int GRID_H     = gct_pkg::GRID_H_DEF,
    parameter int INDEX_BITS = gct_pkg::INDEX_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  gct_pkg::gct_in_t   s_data,
    input  gct_pkg::gct_cmd_t  cmd,
    output gct_pkg::gct_sts_t  sts,
    output logic               m_valid,
    input  logic               m_ready,
    output gct_pkg::gct_out_t  m_data
);
    import gct_pkg::*;

    localparam int CELLS  = GRID_W * GRID_H;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int X_W    = $clog2(GRID_W + 2);
    localparam int ENT_W  = INDEX_BITS + 1;

    typedef struct packed {
        logic [INDEX_BITS-1:0] a;
        logic [INDEX_BITS-1:0] b;
        logic [INDEX_BITS-1:0] c;
    } tri_t;

    // Captured input word
    logic [COORD_W-1:0]    x_reg;
    logic [COORD_W-1:0]    y_reg;
    logic [INDEX_BITS-1:0] vi_reg;
    logic                  ins_ok_reg;
    logic                  up_ok_reg;

    // Clearing sweep
    logic [ADDR_W-1:0] clr_addr_reg;

    // Row scan pipeline
    logic [X_W-1:0]        rd_x_reg;
    logic                  ev_valid_reg;
    logic                  ev_rin_reg;
    logic                  sub_reg;
    logic                  ld_v_reg;
    logic                  lu_v_reg;
    logic [INDEX_BITS-1:0] ld_i_reg;
    logic [INDEX_BITS-1:0] lu_i_reg;

    // Pending triangle and output register
    logic     p_valid_reg;
    tri_t     p_tri_reg;
    logic     m_valid_reg;
    gct_out_t m_data_reg;

    // Grid store ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr_a;
    logic [ADDR_W-1:0] ram_raddr_b;
    logic [ENT_W-1:0]  rd_a;
    logic [ENT_W-1:0]  rd_b;

    logic              col_in;
    logic [ADDR_W-1:0] ins_addr;
    logic [ADDR_W-1:0] scan_addr_d;
    logic [ADDR_W-1:0] scan_addr_u;
    logic [COORD_W:0]  y_up;

    logic       hld, hrd, hlu, hru;
    logic [1:0] n_tri;
    tri_t       tri_sel;
    logic       o_free;
    logic       can_take;
    logic       advance;
    logic       tri_fire;
    logic       issue;

    gct_ram #(
        .WIDTH  (ENT_W),
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_grid (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Cell addresses: row * GRID_W + column
    assign y_up     = {1'b0, y_reg} + (COORD_W + 1)'(1);
    assign ins_addr = ADDR_W'(y_reg) * ADDR_W'(GRID_W) + ADDR_W'(x_reg);
    assign col_in   = (32'(rd_x_reg) < GRID_W);
    assign scan_addr_d = col_in ?
        (ADDR_W'(y_reg) * ADDR_W'(GRID_W) + ADDR_W'(rd_x_reg)) : '0;
    assign scan_addr_u = (col_in && up_ok_reg) ?
        (ADDR_W'(y_up) * ADDR_W'(GRID_W) + ADDR_W'(rd_x_reg)) : '0;

    // Corner presence of the column under evaluation
    assign hld = ld_v_reg;
    assign hlu = lu_v_reg;
    assign hrd = ev_rin_reg && rd_a[INDEX_BITS];
    assign hru = ev_rin_reg && up_ok_reg && rd_b[INDEX_BITS];

    // Pick the triangle for this column and sub-step
    always_comb begin
        n_tri   = 2'd0;
        tri_sel = '0;
        unique case ({hld, hrd, hlu, hru})
            4'b0111: begin
                n_tri   = 2'd1;
                tri_sel = '{a: lu_i_reg, b: rd_a[INDEX_BITS-1:0],
                            c: rd_b[INDEX_BITS-1:0]};
            end
            4'b1111: begin
                n_tri = 2'd2;
                if (!sub_reg) begin
                    tri_sel = '{a: ld_i_reg, b: rd_b[INDEX_BITS-1:0], c: lu_i_reg};
                end else begin
                    tri_sel = '{a: ld_i_reg, b: rd_a[INDEX_BITS-1:0],
                                c: rd_b[INDEX_BITS-1:0]};
                end
            end
            4'b1101: begin
                n_tri   = 2'd1;
                tri_sel = '{a: ld_i_reg, b: rd_a[INDEX_BITS-1:0],
                            c: rd_b[INDEX_BITS-1:0]};
            end
            4'b1011: begin
                n_tri   = 2'd1;
                tri_sel = '{a: ld_i_reg, b: rd_b[INDEX_BITS-1:0], c: lu_i_reg};
            end
            4'b1110: begin
                n_tri   = 2'd1;
                tri_sel = '{a: lu_i_reg, b: ld_i_reg, c: rd_a[INDEX_BITS-1:0]};
            end
            default: begin
                n_tri = 2'd0;
            end
        endcase
    end

    // Scan flow: a new triangle needs the pending slot free or drainable
    assign o_free   = !m_valid_reg || m_ready;
    assign can_take = !p_valid_reg || o_free;
    always_comb begin
        advance  = 1'b1;
        tri_fire = 1'b0;
        if (cmd.scan && ev_valid_reg) begin
            unique case (n_tri)
                2'd0: begin
                    advance = 1'b1;
                end
                2'd1: begin
                    advance  = can_take;
                    tri_fire = can_take;
                end
                default: begin
                    advance  = can_take && sub_reg;
                    tri_fire = can_take;
                end
            endcase
        end
    end
    assign issue = cmd.scan && advance && (32'(rd_x_reg) <= GRID_W);

    // Grid store access
    assign ram_re      = cmd.ins_rd || issue;
    assign ram_raddr_a = cmd.ins_rd ? ins_addr : scan_addr_d;
    assign ram_raddr_b = scan_addr_u;
    assign ram_we      = cmd.clr_wr || (cmd.ins_wr && ins_ok_reg && !rd_a[INDEX_BITS]);
    assign ram_waddr   = cmd.clr_wr ? clr_addr_reg : ins_addr;
    assign ram_wdata   = cmd.clr_wr ? '0 : {1'b1, vi_reg};

    // Capture the accepted word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg      <= s_data.cell_x;
            y_reg      <= s_data.cell_y;
            vi_reg     <= INDEX_BITS'(s_data.vertex_index);
            ins_ok_reg <= (32'(s_data.cell_x) < GRID_W) && (32'(s_data.cell_y) < GRID_H);
            up_ok_reg  <= (32'(s_data.cell_y) + 32'd1 < GRID_H);
        end
    end

    // Advance the clearing sweep, wrap after the final cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_wr) begin
            if (sts.clr_last) begin
                clr_addr_reg <= '0;
            end else begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    // Scan pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_x_reg     <= '0;
            ev_valid_reg <= 1'b0;
            ev_rin_reg   <= 1'b0;
            sub_reg      <= 1'b0;
            ld_v_reg     <= 1'b0;
            lu_v_reg     <= 1'b0;
        end else if (cmd.load) begin
            rd_x_reg     <= '0;
            ev_valid_reg <= 1'b0;
            sub_reg      <= 1'b0;
            ld_v_reg     <= 1'b0;
            lu_v_reg     <= 1'b0;
        end else if (cmd.scan) begin
            if (ev_valid_reg && advance) begin
                ld_v_reg <= hrd;
                lu_v_reg <= hru;
                ld_i_reg <= rd_a[INDEX_BITS-1:0];
                lu_i_reg <= rd_b[INDEX_BITS-1:0];
                sub_reg  <= 1'b0;
            end else if (tri_fire) begin
                sub_reg <= 1'b1;
            end
            if (issue) begin
                ev_rin_reg <= col_in;
                rd_x_reg   <= rd_x_reg + X_W'(1);
            end
            if (issue || advance) begin
                ev_valid_reg <= issue;
            end
        end
    end

    // Pending triangle and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (tri_fire) begin
                p_valid_reg <= 1'b1;
                p_tri_reg   <= tri_sel;
            end else if (cmd.flush && o_free) begin
                p_valid_reg <= 1'b0;
            end

            if (tri_fire && p_valid_reg) begin
                m_valid_reg             <= 1'b1;
                m_data_reg.corner_a     <= CORNER_W'(p_tri_reg.a);
                m_data_reg.corner_b     <= CORNER_W'(p_tri_reg.b);
                m_data_reg.corner_c     <= CORNER_W'(p_tri_reg.c);
                m_data_reg.has_triangle <= 1'b1;
                m_data_reg.last         <= 1'b0;
            end else if (cmd.flush && o_free) begin
                m_valid_reg             <= 1'b1;
                m_data_reg.corner_a     <= p_valid_reg ? CORNER_W'(p_tri_reg.a) : '0;
                m_data_reg.corner_b     <= p_valid_reg ? CORNER_W'(p_tri_reg.b) : '0;
                m_data_reg.corner_c     <= p_valid_reg ? CORNER_W'(p_tri_reg.c) : '0;
                m_data_reg.has_triangle <= p_valid_reg;
                m_data_reg.last         <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.clr_last   = (clr_addr_reg == ADDR_W'(CELLS - 1));
    assign sts.scan_done  = (32'(rd_x_reg) > GRID_W) && !ev_valid_reg;
    assign sts.flush_done = o_free;

`ifndef SYNTH
    // A pending triangle is only displaced into a free output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (tri_fire && p_valid_reg) |-> (!m_valid_reg || m_ready))
        else $error("pending triangle displaced into a busy output register");

    // Closing a row leaves nothing pending
    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.flush && o_free) |=> !p_valid_reg)
        else $error("triangle left pending after the row was closed");

    // An empty-row word is always the final word of its row
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.has_triangle) |-> m_data_reg.last)
        else $error("empty result word without last");
`endif

endmodule

/* sv/grid_cell_triangulator.sv */
`timescale 1ns / 1ps
// Top level of the grid cell triangulator: controller plus datapath.
// Depends on gct_pkg, gct_ctrl, gct_datapath and gct_ram.
//
// The block keeps a GRID_W x GRID_H occupancy grid of vertex indices in a
// two-read-port RAM. After reset it runs a clearing pass over all
// GRID_W*GRID_H cells (1024 at the default size) during which s_ready stays
// low; a clear word runs the same pass. An insert word reads the cell, then
// writes it if it lies in the grid and is still empty. A triangulate word
// reads one column (down and up cell) per cycle from the two RAM read ports
// while the result side does not stall; a column that yields two triangles
// holds the scan while it gives its second one. Results of a row leave
// through an output register, the final one carrying last; a row without
// triangles gives one word with has_triangle low and last high.
module grid_cell_triangulator #(
    parameter int GRID_W     = gct_pkg::GRID_W_DEF,
    parameter int GRID_H     = gct_pkg::GRID_H_DEF,
    parameter int INDEX_BITS = gct_pkg::INDEX_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gct_pkg::gct_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output gct_pkg::gct_out_t m_data
);
    import gct_pkg::*;

    gct_cmd_t cmd;
    gct_sts_t sts;

    gct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .kind    (s_data.kind),
        .sts     (sts),
        .cmd     (cmd)
    );

    gct_datapath #(
        .GRID_W     (GRID_W),
        .GRID_H     (GRID_H),
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
